>>> design/tott_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tott_pkg
// Shared constants, types and elaboration-time helpers for the thermal
// overload trip time pipeline.
// ----------------------------------------------------------------------------
package tott_pkg;

   localparam int IN_FRAC_BITS = 16;
   localparam int P_FRAC_BITS  = 12;
   localparam int LOG_FB       = 24;
   localparam int MANT_W       = 31;
   localparam int K_W          = 5;
   localparam int IN_W         = 24;
   localparam int P_W          = 16;
   localparam int TP_W         = 32;
   localparam int AT_W         = IN_W + TP_W;
   localparam int D_W          = 40;
   localparam int LNV_W        = 29;
   localparam int SPLIT        = 28;
   localparam int T_SHIFT      = IN_FRAC_BITS + LOG_FB - SPLIT;
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   typedef enum logic [1:0] {
      CSR_GAIN_A        = 2'd0,
      CSR_EXPONENT_P    = 2'd1,
      CSR_OFFSET_Q      = 2'd2,
      CSR_TIME_CONSTANT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NOTRIP = 2'd1,
      STAT_SAT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [K_W-1:0]    k;
      logic [MANT_W-1:0] m;
   } norm_type;

   // top bit index and mantissa aligned to Q1.30
   function automatic norm_type norm(input logic [MANT_W-1:0] v);
      norm_type r;
      r.k = '0;
      for (int i = 0; i < MANT_W; i++) begin
         if (v[i]) r.k = K_W'(i);
      end
      r.m = v << (K_W'(MANT_W - 1) - r.k);
      return r;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bitv > rem) bitv = bitv >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (bitv != 0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-idx) in Q1.30, built by repeated square roots from 2.0
   function automatic logic [MANT_W-1:0] exp_root(input int idx);
      logic [63:0] c;
      c = 64'd1 << 31;
      for (int i = 1; i <= idx; i++) begin
         c = isqrt64(c << 30);
      end
      return c[MANT_W-1:0];
   endfunction

endpackage

>>> design/tott_log_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tott_log_cell
// One log2 fraction bit: square the Q1.30 mantissa, renormalize, shift
// the bit into the fraction word and pass the sideband on.
// ----------------------------------------------------------------------------
module tott_log_cell import tott_pkg::*; #(
   parameter int PW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_i,
   input  logic [MANT_W-1:0] mant_i,
   input  logic [LOG_FB-1:0] frac_i,
   input  logic [PW-1:0]     pay_i,
   output logic              vld_o,
   output logic [MANT_W-1:0] mant_o,
   output logic [LOG_FB-1:0] frac_o,
   output logic [PW-1:0]     pay_o
);

   logic [2*MANT_W-1:0] sq;
   logic [MANT_W:0]     sqs;
   logic [MANT_W-1:0]   mant_in, mant_ff;
   logic [LOG_FB-1:0]   frac_in, frac_ff;
   logic [PW-1:0]       pay_ff;
   logic                vld_ff;

   always_comb begin
      sq  = mant_i * mant_i;
      sqs = sq[2*MANT_W-1:MANT_W-1];
      if (sqs[MANT_W]) begin
         mant_in = sqs[MANT_W:1];
         frac_in = {frac_i[LOG_FB-2:0], 1'b1};
      end else begin
         mant_in = sqs[MANT_W-1:0];
         frac_in = {frac_i[LOG_FB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mant_ff <= mant_in;
         frac_ff <= frac_in;
         pay_ff  <= pay_i;
      end
   end

   assign vld_o  = vld_ff;
   assign mant_o = mant_ff;
   assign frac_o = frac_ff;
   assign pay_o  = pay_ff;

endmodule

>>> design/tott_exp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tott_exp_cell
// One exp2 fraction bit: multiply the Q1.30 accumulator by 2^(2^-IDX)
// when the matching exponent bit is set, pass the rest on.
// ----------------------------------------------------------------------------
module tott_exp_cell import tott_pkg::*; #(
   parameter int IDX = 1,
   parameter int PW  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_i,
   input  logic [MANT_W-1:0] acc_i,
   input  logic [LOG_FB-1:0] frac_i,
   input  logic [PW-1:0]     pay_i,
   output logic              vld_o,
   output logic [MANT_W-1:0] acc_o,
   output logic [LOG_FB-1:0] frac_o,
   output logic [PW-1:0]     pay_o
);

   localparam logic [MANT_W-1:0] ROOT = exp_root(IDX);

   logic [2*MANT_W-1:0] prod;
   logic [MANT_W-1:0]   acc_in, acc_ff;
   logic [LOG_FB-1:0]   frac_ff;
   logic [PW-1:0]       pay_ff;
   logic                vld_ff;

   always_comb begin
      prod   = acc_i * ROOT;
      acc_in = frac_i[LOG_FB-IDX] ? prod[2*MANT_W-2:MANT_W-1] : acc_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff  <= acc_in;
         frac_ff <= frac_i;
         pay_ff  <= pay_i;
      end
   end

   assign vld_o  = vld_ff;
   assign acc_o  = acc_ff;
   assign frac_o = frac_ff;
   assign pay_o  = pay_ff;

endmodule

>>> design/thermal_overload_trip_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_overload_trip_time
// Trip time t = A * Tp * ln(x^P / (x^P - Q)) for one current word per cycle.
// ----------------------------------------------------------------------------
// One word is taken each cycle; the whole pipe holds while a result waits
// under rsp_stall. The pipe is built from three rows of 24 cells (log2 of x
// and Q side by side, exp2 of the ratio, log2 of one minus the ratio), one
// fraction bit per cell, plus ten staging registers for normalizing, scaling
// and the final products.
// Status 0 is a valid time, 1 means no trip (x^P at or below Q, or a
// vanishing log term) with time 0, and 2 a saturated time of all ones.
// ----------------------------------------------------------------------------
module thermal_overload_trip_time import tott_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [IN_W-1:0]     req_current_multiple,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_trip_time,
   output logic [1:0]          rsp_status
);

   localparam logic signed [29:0] ONE_IN = 30'(IN_FRAC_BITS) <<< LOG_FB;
   localparam logic [29:0] THIRTY = 30'(30) << LOG_FB;

   typedef struct packed {
      logic            xzero;
      logic            qzero;
      logic [P_W-1:0]  p;
      logic [AT_W-1:0] at;
      logic [K_W-1:0]  kx;
   } lx_pay_type;

   typedef struct packed {
      logic            nt;
      logic [4:0]      sh;
      logic [AT_W-1:0] at;
   } ex_pay_type;

   typedef struct packed {
      logic            nt;
      logic [AT_W-1:0] at;
      logic [K_W-1:0]  ks;
   } ls_pay_type;

   localparam int LXW = $bits(lx_pay_type);
   localparam int EXW = $bits(ex_pay_type);
   localparam int LSW = $bits(ls_pay_type);

   logic [23:0] gain_a_ff;
   logic [15:0] exponent_p_ff;
   logic [23:0] offset_q_ff;
   logic [31:0] time_constant_ff;

   logic en;
   norm_type xn, qn;

   // stage A
   logic        va_ff;
   lx_pay_type  pa_ff;
   logic [MANT_W-1:0] mxa_ff, mqa_ff;
   logic [K_W-1:0]    kqa_ff;

   // log rows for x and Q
   logic              lvld [0:LOG_FB];
   logic [MANT_W-1:0] lm   [0:LOG_FB];
   logic [LOG_FB-1:0] lf   [0:LOG_FB];
   logic [LXW-1:0]    lp   [0:LOG_FB];
   logic              qvld [0:LOG_FB];
   logic [MANT_W-1:0] qm   [0:LOG_FB];
   logic [LOG_FB-1:0] qf   [0:LOG_FB];
   logic [K_W-1:0]    qp   [0:LOG_FB];

   lx_pay_type lxo;

   // stages B, C, D
   logic                    vb_ff, vc_ff, vd_ff;
   logic signed [29:0]      lx_in, lq_in, lxb_ff, lqb_ff, lqc_ff;
   lx_pay_type              pb_ff, pc_ff;
   logic signed [46:0]      prod_in, prodc_ff;
   logic signed [D_W-1:0]   y, d;
   logic signed [D_W-LOG_FB-1:0] n;
   logic                    nt_d;
   logic [4:0]              sh_d;
   ex_pay_type              pd_ff;
   logic [LOG_FB-1:0]       fd_ff;

   // exp row
   logic              evld [0:LOG_FB];
   logic [MANT_W-1:0] em   [0:LOG_FB];
   logic [LOG_FB-1:0] ef   [0:LOG_FB];
   logic [EXW-1:0]    ep   [0:LOG_FB];
   ex_pay_type        exo;

   // stages F, G
   logic              vf_ff, vg_ff;
   logic [MANT_W-1:0] r30, s_in, sf_ff;
   logic              ntf_ff;
   logic [AT_W-1:0]   atf_ff;
   norm_type          sn;
   ls_pay_type        pg_ff;
   logic [MANT_W-1:0] mg_ff;

   // log row for s
   logic              svld [0:LOG_FB];
   logic [MANT_W-1:0] sm   [0:LOG_FB];
   logic [LOG_FB-1:0] sf   [0:LOG_FB];
   logic [LSW-1:0]    sp   [0:LOG_FB];
   ls_pay_type        lso;

   // stages H, I, J, K
   logic              vh_ff, vi_ff, vj_ff;
   logic [29:0]       nl_in;
   logic [LNV_W-1:0]  nlh_ff;
   logic              nth_ff, nti_ff, ntj_ff;
   logic [AT_W-1:0]   ath_ff, ati_ff;
   logic [LNV_W+31:0] lnv_prod;
   logic [LNV_W-1:0]  lnvi_ff;
   logic [AT_W-SPLIT+LNV_W-1:0] aj_ff, bj_ff;
   logic [AT_W-SPLIT+LNV_W:0]   tsum;
   logic [AT_W-SPLIT+LNV_W:0]   tval;
   logic              rsp_valid_ff;
   logic [31:0]       trip_in, trip_ff;
   status_type        status_in, status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_a_ff        <= 24'd65536;
         exponent_p_ff    <= 16'd8192;
         offset_q_ff      <= 24'd72253;
         time_constant_ff <= 32'd159744;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_A:        gain_a_ff        <= csr_data[23:0];
            CSR_EXPONENT_P:    exponent_p_ff    <= csr_data[15:0];
            CSR_OFFSET_Q:      offset_q_ff      <= csr_data[23:0];
            CSR_TIME_CONSTANT: time_constant_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      xn = norm({{(MANT_W-IN_W){1'b0}}, req_current_multiple});
      qn = norm({{(MANT_W-IN_W){1'b0}}, offset_q_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff.xzero <= (req_current_multiple == '0);
         pa_ff.qzero <= (offset_q_ff == '0);
         pa_ff.p     <= exponent_p_ff;
         pa_ff.at    <= gain_a_ff * time_constant_ff;
         pa_ff.kx    <= xn.k;
         mxa_ff      <= xn.m;
         mqa_ff      <= qn.m;
         kqa_ff      <= qn.k;
      end
   end

   assign lvld[0] = va_ff;
   assign lm[0]   = mxa_ff;
   assign lf[0]   = '0;
   assign lp[0]   = pa_ff;
   assign qvld[0] = va_ff;
   assign qm[0]   = mqa_ff;
   assign qf[0]   = '0;
   assign qp[0]   = kqa_ff;

   for (genvar i = 0; i < LOG_FB; i++) begin : g_lx
      tott_log_cell #(.PW(LXW)) u_xcell (
         .clock(clock), .reset(reset), .en(en),
         .vld_i(lvld[i]), .mant_i(lm[i]), .frac_i(lf[i]), .pay_i(lp[i]),
         .vld_o(lvld[i+1]), .mant_o(lm[i+1]), .frac_o(lf[i+1]), .pay_o(lp[i+1])
      );
      tott_log_cell #(.PW(K_W)) u_qcell (
         .clock(clock), .reset(reset), .en(en),
         .vld_i(qvld[i]), .mant_i(qm[i]), .frac_i(qf[i]), .pay_i(qp[i]),
         .vld_o(qvld[i+1]), .mant_o(qm[i+1]), .frac_o(qf[i+1]), .pay_o(qp[i+1])
      );
   end

   always_comb begin
      lxo   = lx_pay_type'(lp[LOG_FB]);
      lx_in = $signed({1'b0, lxo.kx, lf[LOG_FB]}) - ONE_IN;
      lq_in = $signed({1'b0, qp[LOG_FB], qf[LOG_FB]}) - ONE_IN;
   end

   always_comb begin
      prod_in = $signed({1'b0, pb_ff.p}) * lxb_ff;
   end

   always_comb begin
      y = D_W'(prodc_ff >>> P_FRAC_BITS);
      if (pc_ff.xzero) y = '0;
      d    = D_W'(lqc_ff) - y;
      n    = d[D_W-1:LOG_FB];
      nt_d = (pc_ff.xzero && (pc_ff.p != '0)) || pc_ff.qzero || !d[D_W-1] ||
             (n < -(D_W-LOG_FB)'(31));
      sh_d = 5'(-n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= lvld[LOG_FB];
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lxb_ff   <= lx_in;
         lqb_ff   <= lq_in;
         pb_ff    <= lxo;
         prodc_ff <= prod_in;
         lqc_ff   <= lqb_ff;
         pc_ff    <= pb_ff;
         pd_ff.nt <= nt_d;
         pd_ff.sh <= sh_d;
         pd_ff.at <= pc_ff.at;
         fd_ff    <= d[LOG_FB-1:0];
      end
   end

   assign evld[0] = vd_ff;
   assign em[0]   = MANT_W'(1) << (MANT_W - 1);
   assign ef[0]   = fd_ff;
   assign ep[0]   = pd_ff;

   for (genvar i = 0; i < LOG_FB; i++) begin : g_ex
      tott_exp_cell #(.IDX(i + 1), .PW(EXW)) u_ecell (
         .clock(clock), .reset(reset), .en(en),
         .vld_i(evld[i]), .acc_i(em[i]), .frac_i(ef[i]), .pay_i(ep[i]),
         .vld_o(evld[i+1]), .acc_o(em[i+1]), .frac_o(ef[i+1]), .pay_o(ep[i+1])
      );
   end

   always_comb begin
      exo  = ex_pay_type'(ep[LOG_FB]);
      r30  = em[LOG_FB] >> exo.sh;
      s_in = (MANT_W'(1) << (MANT_W - 1)) - r30;
      sn   = norm(sf_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= evld[LOG_FB];
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sf_ff    <= s_in;
         ntf_ff   <= exo.nt || (r30 == '0);
         atf_ff   <= exo.at;
         mg_ff    <= sn.m;
         pg_ff.nt <= ntf_ff;
         pg_ff.at <= atf_ff;
         pg_ff.ks <= sn.k;
      end
   end

   assign svld[0] = vg_ff;
   assign sm[0]   = mg_ff;
   assign sf[0]   = '0;
   assign sp[0]   = pg_ff;

   for (genvar i = 0; i < LOG_FB; i++) begin : g_ls
      tott_log_cell #(.PW(LSW)) u_scell (
         .clock(clock), .reset(reset), .en(en),
         .vld_i(svld[i]), .mant_i(sm[i]), .frac_i(sf[i]), .pay_i(sp[i]),
         .vld_o(svld[i+1]), .mant_o(sm[i+1]), .frac_o(sf[i+1]), .pay_o(sp[i+1])
      );
   end

   always_comb begin
      lso      = ls_pay_type'(sp[LOG_FB]);
      nl_in    = THIRTY - {1'b0, lso.ks, sf[LOG_FB]};
      lnv_prod = nlh_ff * LN2_Q32;
      tsum     = {1'b0, aj_ff} + (AT_W-SPLIT+LNV_W+1)'(bj_ff >> SPLIT);
      tval     = tsum >> T_SHIFT;
      if (ntj_ff) begin
         trip_in   = '0;
         status_in = STAT_NOTRIP;
      end else if (tval > (AT_W-SPLIT+LNV_W+1)'(32'hFFFFFFFF)) begin
         trip_in   = '1;
         status_in = STAT_SAT;
      end else begin
         trip_in   = tval[31:0];
         status_in = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vh_ff        <= 1'b0;
         vi_ff        <= 1'b0;
         vj_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vh_ff        <= svld[LOG_FB];
         vi_ff        <= vh_ff;
         vj_ff        <= vi_ff;
         rsp_valid_ff <= vj_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nlh_ff    <= nl_in[LNV_W-1:0];
         nth_ff    <= lso.nt || (nl_in == '0);
         ath_ff    <= lso.at;
         lnvi_ff   <= lnv_prod[LNV_W+31:32];
         nti_ff    <= nth_ff;
         ati_ff    <= ath_ff;
         aj_ff     <= ati_ff[AT_W-1:SPLIT] * lnvi_ff;
         bj_ff     <= ati_ff[SPLIT-1:0] * lnvi_ff;
         ntj_ff    <= nti_ff;
         trip_ff   <= trip_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_trip_time = trip_ff;
   assign rsp_status    = status_ff;

`ifndef SYNTHESIS
   a_rows_aligned: assert property (@(posedge clock) disable iff (reset)
      lvld[LOG_FB] == qvld[LOG_FB])
      else $error("log rows out of step");
   a_notrip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NOTRIP) |-> rsp_trip_time == '0)
      else $error("no-trip word carries a time");
   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_SAT) |-> rsp_trip_time == '1)
      else $error("saturated word not all ones");
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> va_ff)
      else $error("accepted word lost at entry");
`endif

endmodule
